// ===== rtl/mlp231_pkg.sv =====
// Shared types, reset values and the sigmoid table for the 2-3-1 perceptron.
// No dependencies; the lane, merge and top modules refer to it by scoped names.
`timescale 1ns / 1ps

package mlp231_pkg;

  localparam int SigEntries    = 256;
  localparam int HiddenNeurons = 3;
  localparam int SigIdxW       = $clog2(SigEntries);

  // Packed configuration registers carry at most three 16-bit lanes
  localparam int CfgLanes = 3;
  localparam int CfgW     = 16 * CfgLanes;

  localparam int DistW  = 12;
  localparam int WordW  = 16;
  localparam int ProdW  = WordW + DistW;   // weight times distance
  localparam int ZW     = ProdW + 2;       // bias plus two products
  localparam int HidFrac = 8;
  localparam int OutFrac = 24;
  localparam int HidOffW = HidFrac + 4;    // [-8,8) spans 16 units
  localparam int OutOffW = OutFrac + 4;
  localparam int HidIdxProdW = HidOffW + $clog2(SigEntries + 1);
  localparam int OutIdxProdW = OutOffW + $clog2(SigEntries + 1);
  localparam int OutProdW = WordW + WordW + 1;  // signed weight times unsigned activation
  localparam int AccW     = OutProdW + $clog2(HiddenNeurons + 1);

  localparam logic [CfgW-1:0]  HwFirstRst  = 48'h0000_0000_0000;
  localparam logic [CfgW-1:0]  HwSecondRst = 48'hF600_F600_F600;
  localparam logic [CfgW-1:0]  HbRst       = 48'h0500_0500_0500;
  localparam logic [CfgW-1:0]  OwRst       = 48'h0100_0100_0100;
  localparam logic [WordW-1:0] ObRst       = 16'hFE80;

  typedef enum logic [2:0] {
    CFG_HW_FIRST  = 3'd0,
    CFG_HW_SECOND = 3'd1,
    CFG_HB        = 3'd2,
    CFG_OW        = 3'd3,
    CFG_OB        = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic mul_en;  // load the product registers
    logic sig_en;  // load the activation register
  } stage_ctrl_t;

  typedef logic [WordW-1:0] sig_rom_t [SigEntries];

  // Shift-subtract quotient, used only while the table is built at elaboration
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      rem = {rem[62:0], num[bit_i]};
      if (rem >= den) begin
        rem        = rem - den;
        quo[bit_i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid samples at -8 + 16*i/N, built from a Q31 power series of e^(-8/N)
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t          rom;
    longint unsigned   h;
    longint unsigned   term;
    longint unsigned   c;
    longint unsigned   p;
    longint unsigned   d;
    longint unsigned   q;
    longint unsigned   one;
    int                hi;
    int                lo;
    one  = 64'd1 << 31;
    h    = (64'd8 << 31) / SigEntries;
    term = one;
    c    = one;
    p    = one;
    for (int i = 0; i < SigEntries; i++) rom[i] = '0;
    for (int k = 1; k <= 10; k++) begin
      term = udiv64((term * h) >> 31, 64'(k));
      if ((k % 2) == 1) c = c - term;
      else c = c + term;
    end
    for (int m = 0; m <= SigEntries; m++) begin
      if (((SigEntries + m) % 2) == 0) begin
        d  = one + p;
        hi = (SigEntries + m) / 2;
        lo = (SigEntries - m) / 2;
        if (hi < SigEntries) begin
          q = udiv64((64'd1 << 47) + (d >> 1), d);
          rom[hi] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
        end
        if (m > 0) begin
          q = udiv64((p << 16) + (d >> 1), d);
          rom[lo] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
        end
      end
      p = (p * c + (64'd1 << 30)) >> 31;
    end
    return rom;
  endfunction

  localparam sig_rom_t SigRom = build_sig_rom();

endpackage

// ===== rtl/mlp_two_three_one_sigmoid.sv =====
// Top level of the 2-3-1 sigmoid perceptron: config registers, stage control, lanes.
// Depends on mlp231_pkg, mlp231_lane and mlp231_merge.
//
// Usage:
//  s_axis carries one request per beat: two signed 12-bit distances. m_axis
//  returns one 16-bit unsigned Q0.16 activation per request, in order.
//  cfg_* writes one register per handshake (index 0..4); cfg_ready_o is always
//  high and writes to other indexes are dropped. Write only while no request
//  is in flight.
//  Four register stages: hidden products, hidden sigmoid, output products,
//  output sigmoid. One request per cycle is sustained while m_axis_tready
//  stays high; the hidden lanes each own two multipliers and the merge stage
//  owns one multiplier per hidden neuron.
//  Each stage holds its item while the next one is full and stalled, so empty
//  stages still fill while m_axis_tready is low; s_axis_tready drops once all
//  four stages hold items and m_axis_tready is low.
//  Reset clears all stage valid bits and loads the default weights and biases.
`timescale 1ns / 1ps

module mlp_two_three_one_sigmoid (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] horizontal_distance, [23:12] vertical_distance
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] activation
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  localparam int H = mlp231_pkg::HiddenNeurons;
  localparam int W = mlp231_pkg::WordW;

  logic [mlp231_pkg::CfgW-1:0] hw1_q, hw2_q, hb_q, ow_q;
  logic [W-1:0]                ob_q;

  logic [3:0] vld_q, vld_d;
  logic [3:0] adv;

  logic signed [mlp231_pkg::DistW-1:0] dx, dy;
  logic [H-1:0][W-1:0] hid, ow_lane;
  mlp231_pkg::stage_ctrl_t lane_ctrl, merge_ctrl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw1_q <= mlp231_pkg::HwFirstRst;
      hw2_q <= mlp231_pkg::HwSecondRst;
      hb_q  <= mlp231_pkg::HbRst;
      ow_q  <= mlp231_pkg::OwRst;
      ob_q  <= mlp231_pkg::ObRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mlp231_pkg::CFG_HW_FIRST:  hw1_q <= cfg_data_i;
        mlp231_pkg::CFG_HW_SECOND: hw2_q <= cfg_data_i;
        mlp231_pkg::CFG_HB:        hb_q  <= cfg_data_i;
        mlp231_pkg::CFG_OW:        ow_q  <= cfg_data_i;
        mlp231_pkg::CFG_OB:        ob_q  <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the stage after it advances
  always_comb begin
    adv[3] = !vld_q[3] || m_axis_tready;
    for (int k = 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d[0] = adv[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < 4; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld_q[3];

  assign dx = s_axis_tdata[11:0];
  assign dy = s_axis_tdata[23:12];

  assign lane_ctrl  = '{mul_en: adv[0], sig_en: adv[1]};
  assign merge_ctrl = '{mul_en: adv[2], sig_en: adv[3]};

  for (genvar n = 0; n < H; n++) begin : g_lane
    logic [W-1:0] w1, w2, b;
    if (n < mlp231_pkg::CfgLanes) begin : g_cfg
      assign w1          = hw1_q[W*n +: W];
      assign w2          = hw2_q[W*n +: W];
      assign b           = hb_q[W*n +: W];
      assign ow_lane[n]  = ow_q[W*n +: W];
    end else begin : g_zero
      assign w1          = '0;
      assign w2          = '0;
      assign b           = '0;
      assign ow_lane[n]  = '0;
    end

    mlp231_lane u_lane (
      .clk_i  (clk_i),
      .dx_i   (dx),
      .dy_i   (dy),
      .w1_i   (w1),
      .w2_i   (w2),
      .bias_i (b),
      .ctrl_i (lane_ctrl),
      .act_o  (hid[n])
    );
  end

  mlp231_merge u_merge (
    .clk_i    (clk_i),
    .hid_i    (hid),
    .weight_i (ow_lane),
    .bias_i   (ob_q),
    .ctrl_i   (merge_ctrl),
    .act_o    (m_axis_tdata)
  );

endmodule

// ===== rtl/mlp231_lane.sv =====
// One hidden neuron: two weighted inputs plus bias, then sigmoid table lookup.
// Depends on mlp231_pkg for widths, control struct and the sigmoid table.
`timescale 1ns / 1ps

module mlp231_lane (
  input  logic                                  clk_i,
  input  logic signed [mlp231_pkg::DistW-1:0]   dx_i,
  input  logic signed [mlp231_pkg::DistW-1:0]   dy_i,
  input  logic signed [mlp231_pkg::WordW-1:0]   w1_i,
  input  logic signed [mlp231_pkg::WordW-1:0]   w2_i,
  input  logic signed [mlp231_pkg::WordW-1:0]   bias_i,
  input  mlp231_pkg::stage_ctrl_t               ctrl_i,
  output logic        [mlp231_pkg::WordW-1:0]   act_o
);

  logic signed [mlp231_pkg::ProdW-1:0]       p1_q, p2_q;
  logic signed [mlp231_pkg::ZW-1:0]          z;
  logic        [mlp231_pkg::HidOffW-1:0]     off;
  logic        [mlp231_pkg::HidIdxProdW-1:0] idx_prod;
  logic        [mlp231_pkg::SigIdxW-1:0]     idx;
  logic        [mlp231_pkg::WordW-1:0]       act_d, act_q;

  localparam logic signed [mlp231_pkg::ZW-1:0] Lim =
    mlp231_pkg::ZW'(longint'(8) << mlp231_pkg::HidFrac);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      p1_q <= mlp231_pkg::ProdW'(w1_i) * mlp231_pkg::ProdW'(dx_i);
      p2_q <= mlp231_pkg::ProdW'(w2_i) * mlp231_pkg::ProdW'(dy_i);
    end
  end

  always_comb begin
    z        = mlp231_pkg::ZW'(bias_i) + mlp231_pkg::ZW'(p1_q) + mlp231_pkg::ZW'(p2_q);
    off      = mlp231_pkg::HidOffW'(z + Lim);
    idx_prod = mlp231_pkg::HidIdxProdW'(off) * mlp231_pkg::HidIdxProdW'(mlp231_pkg::SigEntries);
    idx      = mlp231_pkg::SigIdxW'(idx_prod >> mlp231_pkg::HidOffW);
    if (z < -Lim) begin
      act_d = '0;
    end else if (z >= Lim) begin
      act_d = '1;
    end else begin
      act_d = mlp231_pkg::SigRom[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sig_en) begin
      act_q <= act_d;
    end
  end

  assign act_o = act_q;

endmodule

// ===== rtl/mlp231_merge.sv =====
// Output neuron: weights the hidden activations, adds the bias, applies the sigmoid.
// Depends on mlp231_pkg for widths, control struct and the sigmoid table.
`timescale 1ns / 1ps

module mlp231_merge (
  input  logic                                                          clk_i,
  input  logic [mlp231_pkg::HiddenNeurons-1:0][mlp231_pkg::WordW-1:0]   hid_i,
  input  logic [mlp231_pkg::HiddenNeurons-1:0][mlp231_pkg::WordW-1:0]   weight_i,
  input  logic signed [mlp231_pkg::WordW-1:0]                           bias_i,
  input  mlp231_pkg::stage_ctrl_t                                       ctrl_i,
  output logic [mlp231_pkg::WordW-1:0]                                  act_o
);

  localparam logic signed [mlp231_pkg::AccW-1:0] Lim =
    mlp231_pkg::AccW'(longint'(8) << mlp231_pkg::OutFrac);

  logic signed [mlp231_pkg::OutProdW-1:0]    prod_q [mlp231_pkg::HiddenNeurons];
  logic signed [mlp231_pkg::AccW-1:0]        acc;
  logic        [mlp231_pkg::OutOffW-1:0]     off;
  logic        [mlp231_pkg::OutIdxProdW-1:0] idx_prod;
  logic        [mlp231_pkg::SigIdxW-1:0]     idx;
  logic        [mlp231_pkg::WordW-1:0]       act_d, act_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      for (int n = 0; n < mlp231_pkg::HiddenNeurons; n++) begin
        prod_q[n] <= mlp231_pkg::OutProdW'($signed(weight_i[n]))
                   * mlp231_pkg::OutProdW'($signed({1'b0, hid_i[n]}));
      end
    end
  end

  always_comb begin
    acc = mlp231_pkg::AccW'(bias_i) <<< 16;
    for (int n = 0; n < mlp231_pkg::HiddenNeurons; n++) begin
      acc = acc + mlp231_pkg::AccW'(prod_q[n]);
    end
    off      = mlp231_pkg::OutOffW'(acc + Lim);
    idx_prod = mlp231_pkg::OutIdxProdW'(off) * mlp231_pkg::OutIdxProdW'(mlp231_pkg::SigEntries);
    idx      = mlp231_pkg::SigIdxW'(idx_prod >> mlp231_pkg::OutOffW);
    if (acc < -Lim) begin
      act_d = '0;
    end else if (acc >= Lim) begin
      act_d = '1;
    end else begin
      act_d = mlp231_pkg::SigRom[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sig_en) begin
      act_q <= act_d;
    end
  end

  assign act_o = act_q;

endmodule
